// ----- hdl/fixed_partition_fit_allocator_defines.svh -----
// Assertion macros for the partition allocator checker.
// Depends on clk and arst_n being visible where the macros are used.
`ifndef FIXED_PARTITION_FIT_ALLOCATOR_DEFINES_SVH
`define FIXED_PARTITION_FIT_ALLOCATOR_DEFINES_SVH

// antecedent holds in a cycle -> consequent holds in the same cycle
`define FPFA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent holds in a cycle -> consequent holds in the next cycle
`define FPFA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// condition holds at every edge out of reset
`define FPFA_ASSERT_ALW(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

`endif

// ----- hdl/fpfa_pkg.sv -----
// Shared constants, codes and types of the partition allocator.
// No dependencies.
package fpfa_pkg;

	localparam int MAX_BLOCKS = 128;
	localparam int SIZE_BITS  = 16;
	localparam int IDX_BITS   = $clog2(MAX_BLOCKS);
	localparam int CNT_BITS   = 8;
	localparam int TOTAL_BITS = 23;
	localparam int ALU_BITS   = TOTAL_BITS + 1;
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 8;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_REQ  = 1'b1;

	localparam logic [1:0] ST_GRANT = 2'd0;
	localparam logic [1:0] ST_NONE  = 2'd1;
	localparam logic [1:0] ST_LOAD  = 2'd2;
	localparam logic [1:0] ST_RANGE = 2'd3;

	localparam logic [1:0] POL_FIRST = 2'd0;
	localparam logic [1:0] POL_NEXT  = 2'd1;
	localparam logic [1:0] POL_BEST  = 2'd2;
	localparam logic [1:0] POL_WORST = 2'd3;

	localparam logic [CFG_IDX_BITS-1:0] REG_FIT_POLICY  = CFG_IDX_BITS'(0);
	localparam logic [CFG_IDX_BITS-1:0] REG_BLOCK_COUNT = CFG_IDX_BITS'(1);

	typedef struct packed {
		logic                sub;
		logic [ALU_BITS-1:0] a;
		logic [ALU_BITS-1:0] b;
	} alu_req_t;

endpackage

// ----- hdl/fpfa_ifs.sv -----
// Valid/ready channel interfaces: configuration writes, items in, results out.
// Depends on fpfa_pkg.
interface fpfa_cfg_if;
	import fpfa_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [CFG_IDX_BITS-1:0]  index;
	logic [CFG_DATA_BITS-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

interface fpfa_in_if;
	import fpfa_pkg::*;
	logic                 valid;
	logic                 ready;
	logic                 opcode;
	logic [IDX_BITS-1:0]  block_index;
	logic [SIZE_BITS-1:0] size_value;
	modport source (output valid, opcode, block_index, size_value, input ready);
	modport sink (input valid, opcode, block_index, size_value, output ready);
endinterface

interface fpfa_out_if;
	import fpfa_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [1:0]            status;
	logic [IDX_BITS-1:0]   granted_block;
	logic [TOTAL_BITS-1:0] internal_total;
	logic [TOTAL_BITS-1:0] free_total;
	modport source (output valid, status, granted_block, internal_total, free_total,
		input ready);
	modport sink (input valid, status, granted_block, internal_total, free_total,
		output ready);
endinterface

// ----- hdl/fpfa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fpfa_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- hdl/fpfa_alu.sv -----
// Shared add/subtract unit used by the sequencer for scan differences and totals.
// Depends on fpfa_pkg.
module fpfa_alu (
	input  fpfa_pkg::alu_req_t             req,
	output logic [fpfa_pkg::ALU_BITS-1:0]  res
);
	import fpfa_pkg::*;

	assign res = req.sub ? (req.a - req.b) : (req.a + req.b);

endmodule

// ----- hdl/fixed_partition_fit_allocator.sv -----
// Fixed-partition allocator top level: sequencer, size RAM and shared ALU.
// Depends on fpfa_pkg, fpfa_ifs, fpfa_ram, fpfa_alu.
//
// Channels: cfg writes fit_policy (index 0) or block_count (index 1), always
// ready; req carries one item (load a block size, or an allocation request);
// rsp returns one result per item with the running totals.
// A load reads the block's old size (S_LD_RD), takes it off the free total
// if the block was free (S_LD_SUB) and adds the new size (S_LD_ADD); an
// index out of range goes straight to the result. A request scans the
// blocks one per cycle through the size RAM read port and the shared
// subtractor, n = min(block_count, 128); first/next fit stop at first hit.
// req is ready only while the sequencer is idle, one item at a time. The
// result register frees the sequencer: a new item is taken while a result
// waits, and the sequencer holds its finished result until rsp drains.
// Reset clears all blocks to size zero and free, the totals and the next-fit
// pointer; size RAM entries read as zero until loaded, no clearing pass.
module fixed_partition_fit_allocator (
	input logic        clk,
	input logic        arst_n,
	fpfa_cfg_if.sink   cfg,
	fpfa_in_if.sink    req,
	fpfa_out_if.source rsp
);
	import fpfa_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE    = 8'b0000_0001,
		S_LD_RD   = 8'b0000_0010,
		S_LD_SUB  = 8'b0000_0100,
		S_LD_ADD  = 8'b0000_1000,
		S_SCAN    = 8'b0001_0000,
		S_GR_FREE = 8'b0010_0000,
		S_GR_INT  = 8'b0100_0000,
		S_DONE    = 8'b1000_0000
	} state_t;

	state_t state_q;

	logic [1:0]            policy_q;
	logic [CNT_BITS-1:0]   bcount_q;
	logic [MAX_BLOCKS-1:0] used_q;
	logic [MAX_BLOCKS-1:0] szv_q;
	logic [IDX_BITS-1:0]   next_q;
	logic [TOTAL_BITS-1:0] int_q;
	logic [TOTAL_BITS-1:0] free_q;

	logic [IDX_BITS-1:0]   idx_q;
	logic [SIZE_BITS-1:0]  size_q;
	logic [IDX_BITS-1:0]   ptr_q;
	logic [CNT_BITS-1:0]   iss_q;
	logic                  v_s1;
	logic [IDX_BITS-1:0]   idx_s1;
	logic                  found_q;
	logic [IDX_BITS-1:0]   pick_q;
	logic [SIZE_BITS-1:0]  pdiff_q;
	logic [SIZE_BITS-1:0]  psize_q;
	logic [1:0]            rstat_q;

	logic                  ov_q;
	logic [1:0]            ost_q;
	logic [IDX_BITS-1:0]   oblk_q;
	logic [TOTAL_BITS-1:0] oint_q;
	logic [TOTAL_BITS-1:0] ofree_q;

	logic [CNT_BITS-1:0]   n;
	logic [IDX_BITS-1:0]   start_ptr;
	logic [SIZE_BITS-1:0]  rd_data;
	logic [IDX_BITS-1:0]   raddr;
	logic [SIZE_BITS-1:0]  ent_size;
	logic [SIZE_BITS-1:0]  old_size;
	logic [SIZE_BITS-1:0]  diff;
	logic                  issue;
	logic                  hit;
	logic                  better;
	logic                  take;
	logic                  early;
	logic                  scan_end;
	logic                  acc;
	logic                  out_load;
	alu_req_t              alu_req;
	logic [ALU_BITS-1:0]   alu_res;

	function automatic logic [IDX_BITS-1:0] wrap_inc(input logic [IDX_BITS-1:0] i,
		input logic [CNT_BITS-1:0] lim);
		logic [CNT_BITS-1:0] s;
		s = CNT_BITS'(i) + CNT_BITS'(1);
		return (s >= lim) ? '0 : s[IDX_BITS-1:0];
	endfunction

	function automatic logic [ALU_BITS-1:0] ext16(input logic [SIZE_BITS-1:0] v);
		return {{(ALU_BITS-SIZE_BITS){1'b0}}, v};
	endfunction

	function automatic logic [ALU_BITS-1:0] ext23(input logic [TOTAL_BITS-1:0] v);
		return {{(ALU_BITS-TOTAL_BITS){1'b0}}, v};
	endfunction

	assign n = (bcount_q > CNT_BITS'(MAX_BLOCKS)) ? CNT_BITS'(MAX_BLOCKS) : bcount_q;
	assign start_ptr = (policy_q == POL_NEXT && CNT_BITS'(next_q) < n) ? next_q : '0;

	assign cfg.ready = 1'b1;
	assign req.ready = (state_q == S_IDLE);
	assign acc       = req.valid && req.ready;

	assign rsp.valid          = ov_q;
	assign rsp.status         = ost_q;
	assign rsp.granted_block  = oblk_q;
	assign rsp.internal_total = oint_q;
	assign rsp.free_total     = ofree_q;

	assign raddr = (state_q == S_LD_RD) ? idx_q : ptr_q;

	fpfa_ram #(
		.WIDTH(SIZE_BITS),
		.DEPTH(MAX_BLOCKS)
	) u_sizes (
		.clk  (clk),
		.we   (state_q == S_LD_ADD),
		.waddr(idx_q),
		.wdata(size_q),
		.raddr(raddr),
		.rdata(rd_data)
	);

	fpfa_alu u_alu (
		.req(alu_req),
		.res(alu_res)
	);

	assign ent_size = szv_q[idx_s1] ? rd_data : '0;
	assign old_size = (szv_q[idx_q] && !used_q[idx_q]) ? rd_data : '0;
	assign diff     = alu_res[SIZE_BITS-1:0];
	assign issue    = (iss_q < n);
	assign hit      = (state_q == S_SCAN) && v_s1 && !used_q[idx_s1] && !alu_res[ALU_BITS-1];
	assign better   = !found_q || (policy_q == POL_BEST && diff < pdiff_q)
		|| (policy_q == POL_WORST && diff > pdiff_q);
	assign take     = hit && better;
	assign early    = take && (policy_q == POL_FIRST || policy_q == POL_NEXT);
	assign scan_end = early || (!issue && !v_s1);
	assign out_load = (state_q == S_DONE) && (!ov_q || rsp.ready);

	always_comb begin
		alu_req = '0;
		unique case (state_q)
			S_LD_SUB: begin
				alu_req = '{sub: 1'b1, a: ext23(free_q), b: ext16(old_size)};
			end
			S_LD_ADD: begin
				alu_req = '{sub: 1'b0, a: ext23(free_q), b: ext16(size_q)};
			end
			S_SCAN: begin
				alu_req = '{sub: 1'b1, a: ext16(ent_size), b: ext16(size_q)};
			end
			S_GR_FREE: begin
				alu_req = '{sub: 1'b1, a: ext23(free_q), b: ext16(psize_q)};
			end
			S_GR_INT: begin
				alu_req = '{sub: 1'b0, a: ext23(int_q), b: ext16(pdiff_q)};
			end
			default: begin
				alu_req = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= POL_FIRST;
			bcount_q <= CNT_BITS'(MAX_BLOCKS);
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_FIT_POLICY:  policy_q <= cfg.data[1:0];
				REG_BLOCK_COUNT: bcount_q <= cfg.data[CNT_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			used_q  <= '0;
			szv_q   <= '0;
			next_q  <= '0;
			int_q   <= '0;
			free_q  <= '0;
			idx_q   <= '0;
			size_q  <= '0;
			ptr_q   <= '0;
			iss_q   <= '0;
			v_s1    <= 1'b0;
			idx_s1  <= '0;
			found_q <= 1'b0;
			pick_q  <= '0;
			pdiff_q <= '0;
			psize_q <= '0;
			rstat_q <= ST_NONE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						idx_q  <= req.block_index;
						size_q <= req.size_value;
						if (req.opcode == OP_LOAD) begin
							if (CNT_BITS'(req.block_index) >= n) begin
								rstat_q <= ST_RANGE;
								state_q <= S_DONE;
							end else begin
								state_q <= S_LD_RD;
							end
						end else begin
							ptr_q   <= start_ptr;
							iss_q   <= '0;
							v_s1    <= 1'b0;
							found_q <= 1'b0;
							pick_q  <= '0;
							state_q <= S_SCAN;
						end
					end
				end
				S_LD_RD: begin
					state_q <= S_LD_SUB;
				end
				S_LD_SUB: begin
					free_q  <= alu_res[TOTAL_BITS-1:0];
					state_q <= S_LD_ADD;
				end
				S_LD_ADD: begin
					free_q        <= alu_res[TOTAL_BITS-1:0];
					used_q[idx_q] <= 1'b0;
					szv_q[idx_q]  <= 1'b1;
					rstat_q       <= ST_LOAD;
					state_q       <= S_DONE;
				end
				S_SCAN: begin
					if (issue) begin
						ptr_q  <= wrap_inc(ptr_q, n);
						iss_q  <= iss_q + CNT_BITS'(1);
						idx_s1 <= ptr_q;
					end
					v_s1 <= issue && !scan_end;
					if (take) begin
						found_q <= 1'b1;
						pick_q  <= idx_s1;
						pdiff_q <= diff;
						psize_q <= ent_size;
					end
					if (scan_end) begin
						if (found_q || take) begin
							state_q <= S_GR_FREE;
						end else begin
							rstat_q <= ST_NONE;
							state_q <= S_DONE;
						end
					end
				end
				S_GR_FREE: begin
					free_q         <= alu_res[TOTAL_BITS-1:0];
					used_q[pick_q] <= 1'b1;
					state_q        <= S_GR_INT;
				end
				S_GR_INT: begin
					int_q <= alu_res[TOTAL_BITS] ? '1 : alu_res[TOTAL_BITS-1:0];
					if (policy_q == POL_NEXT) begin
						next_q <= wrap_inc(pick_q, n);
					end
					rstat_q <= ST_GRANT;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q    <= 1'b0;
			ost_q   <= ST_NONE;
			oblk_q  <= '0;
			oint_q  <= '0;
			ofree_q <= '0;
		end else if (out_load) begin
			ov_q    <= 1'b1;
			ost_q   <= rstat_q;
			oblk_q  <= (rstat_q == ST_GRANT) ? pick_q : '0;
			oint_q  <= int_q;
			ofree_q <= free_q;
		end else if (rsp.ready) begin
			ov_q <= 1'b0;
		end
	end

endmodule

// ----- hdl/fpfa_chk.sv -----
// Port-level checker for the partition allocator, bound to the top level.
// Depends on fpfa_pkg and fixed_partition_fit_allocator_defines.svh.
`include "fixed_partition_fit_allocator_defines.svh"

module fpfa_chk (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              req_valid,
	input logic                              req_ready,
	input logic                              rsp_valid,
	input logic                              rsp_ready,
	input logic [1:0]                        rsp_status,
	input logic [fpfa_pkg::IDX_BITS-1:0]     rsp_granted_block,
	input logic [fpfa_pkg::TOTAL_BITS-1:0]   rsp_internal_total,
	input logic [fpfa_pkg::TOTAL_BITS-1:0]   rsp_free_total
);
	import fpfa_pkg::*;

	// one item in flight: the sequencer leaves idle on every accepted beat
	`FPFA_ASSERT_NXT(a_busy_after_accept, req_valid && req_ready, !req_ready, "req ready right after accept")

	`FPFA_ASSERT_IMP(a_blk_zero, rsp_valid && rsp_status != ST_GRANT, rsp_granted_block == '0, "granted_block nonzero without grant")

	`FPFA_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable({rsp_status, rsp_granted_block, rsp_internal_total, rsp_free_total}), "stalled result beat changed")

	// fragmentation total only grows (saturating)
	`FPFA_ASSERT_ALW(a_int_mono, rsp_internal_total >= $past(rsp_internal_total), "internal_total decreased")

endmodule

bind fixed_partition_fit_allocator fpfa_chk u_fpfa_chk (
	.clk               (clk),
	.arst_n            (arst_n),
	.req_valid         (req.valid),
	.req_ready         (req.ready),
	.rsp_valid         (rsp.valid),
	.rsp_ready         (rsp.ready),
	.rsp_status        (rsp.status),
	.rsp_granted_block (rsp.granted_block),
	.rsp_internal_total(rsp.internal_total),
	.rsp_free_total    (rsp.free_total)
);
